@@ hdl/typed_operand_stack_core_macros.svh @@
// Assertion macros for the operand stack RTL.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef TYPED_OPERAND_STACK_CORE_MACROS_SVH
`define TYPED_OPERAND_STACK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tos_pkg.sv @@
package tos_pkg;

    // Command codes.
    localparam logic [2:0] ACT_PUSH    = 3'd0;
    localparam logic [2:0] ACT_POP     = 3'd1;
    localparam logic [2:0] ACT_DUP     = 3'd2;
    localparam logic [2:0] ACT_SWAP    = 3'd3;
    localparam logic [2:0] ACT_ROT     = 3'd4;
    localparam logic [2:0] ACT_PICK    = 3'd5;
    localparam logic [2:0] ACT_TO_CHAR = 3'd6;
    localparam logic [2:0] ACT_NOP     = 3'd7;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_PICK  = 2'd3;

    // Entry tags. The fourth code has no meaning and is stored as an integer.
    localparam logic [1:0] TAG_INT    = 2'd0;
    localparam logic [1:0] TAG_CHAR   = 2'd1;
    localparam logic [1:0] TAG_DOUBLE = 2'd2;
    localparam logic [1:0] TAG_UNUSED = 2'd3;

    // One stack entry: raw 64-bit value and its tag.
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  tag;
    } entry_t;

endpackage

@@ hdl/typed_operand_stack_core.sv @@
// Typed operand stack: a stack of tagged 64-bit entries driven by one command
// per input word (push, pop, dup, swap, rot, pick, to_char).
// Input channel: in_valid / in_stall carry action, push_value and push_type.
// Output channel: out_valid / out_stall carry result_value, result_type,
// stack_depth and status, one output word for every input word, in order.
// The command is captured in the input register and passes through the command
// logic into the result register, which raises out_valid. Throughput is one
// word per cycle for every command while out_stall is low. The top three
// entries live in registers; deeper entries sit in a memory with two read
// ports, one keeping the fourth entry ready for pop and one fetching the pick
// target that the current top would select.
// When out_stall is high the result register holds its word, the command in
// the input register waits, and in_stall rises once that register is full.
// Reset empties the stack (depth zero) and drops any word in flight; entry
// storage is not cleared, so no clearing pass is needed.
// Underflow, overflow and a bad pick index return a status and leave the
// stack untouched.
`include "typed_operand_stack_core_macros.svh"

module typed_operand_stack_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [63:0] push_value,
    input  logic [1:0]         push_type,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] result_value,
    output logic [1:0]         result_type,
    output logic [6:0]         stack_depth,
    output logic [1:0]         status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Input register.
    logic            in_valid_reg;
    logic [2:0]      act_reg;
    logic [63:0]     pval_reg;
    logic [1:0]      ptype_reg;

    // Stack state: count and the top three entries.
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    tos_pkg::entry_t top0_reg, top1_reg, top2_reg;
    tos_pkg::entry_t top0_next, top1_next, top2_next;

    // Result register.
    logic            out_valid_reg;
    logic [63:0]     res_value_reg;
    logic [1:0]      res_type_reg;
    logic [6:0]      res_depth_reg;
    logic [1:0]      res_status_reg;

    // Command evaluation.
    logic            exec_fire;
    logic            in_accept;
    logic [CW-1:0]   ex_count;
    tos_pkg::entry_t ex_top0, ex_top1, ex_top2;
    logic [1:0]      ex_status;
    logic            ex_popped;
    logic            ex_push;
    tos_pkg::entry_t ex_push_entry;
    tos_pkg::entry_t push_entry;
    tos_pkg::entry_t pick_entry;
    logic [63:0]     ex_result_value;
    logic [1:0]      ex_result_type;
    logic            stack_full;
    logic [CW-1:0]   pick_rest;
    logic            pick_bad;

    // Memory interface.
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr_a;
    logic [AW-1:0]   mem_raddr_b;
    tos_pkg::entry_t fourth_entry;
    tos_pkg::entry_t pick_fetch;

    // Handshake: the command moves on when the result register is free.
    assign exec_fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !exec_fire;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg   <= action;
            pval_reg  <= push_value;
            ptype_reg <= push_type;
        end
    end

    // Operands for push and pick.
    always_comb
    begin
        push_entry.value = pval_reg;
        push_entry.tag   = (ptype_reg == tos_pkg::TAG_UNUSED) ? tos_pkg::TAG_INT : ptype_reg;
        stack_full = (count_reg == CW'(STACK_DEPTH));
        pick_rest  = count_reg - CW'(1);
        pick_bad   = top0_reg.value[63] || (top0_reg.value >= 64'(pick_rest));
        if (top0_reg.value[AW-1:0] == AW'(0))
        begin
            pick_entry = top1_reg;
        end
        else if (top0_reg.value[AW-1:0] == AW'(1))
        begin
            pick_entry = top2_reg;
        end
        else
        begin
            pick_entry = pick_fetch;
        end
    end

    // Command decode and the new top of stack.
    always_comb
    begin
        ex_count      = count_reg;
        ex_top0       = top0_reg;
        ex_top1       = top1_reg;
        ex_top2       = top2_reg;
        ex_status     = tos_pkg::ST_OK;
        ex_popped     = 1'b0;
        ex_push       = 1'b0;
        ex_push_entry = push_entry;
        unique case (act_reg)
            tos_pkg::ACT_PUSH:
            begin
                if (stack_full)
                begin
                    ex_status = tos_pkg::ST_OVER;
                end
                else
                begin
                    ex_push = 1'b1;
                end
            end
            tos_pkg::ACT_POP:
            begin
                if (count_reg == CW'(0))
                begin
                    ex_status = tos_pkg::ST_UNDER;
                end
                else
                begin
                    ex_popped = 1'b1;
                    ex_count  = count_reg - CW'(1);
                    ex_top0   = top1_reg;
                    ex_top1   = top2_reg;
                    ex_top2   = fourth_entry;
                end
            end
            tos_pkg::ACT_DUP:
            begin
                if (count_reg == CW'(0))
                begin
                    ex_status = tos_pkg::ST_UNDER;
                end
                else if (stack_full)
                begin
                    ex_status = tos_pkg::ST_OVER;
                end
                else
                begin
                    ex_push       = 1'b1;
                    ex_push_entry = top0_reg;
                end
            end
            tos_pkg::ACT_SWAP:
            begin
                if (count_reg < CW'(2))
                begin
                    ex_status = tos_pkg::ST_UNDER;
                end
                else
                begin
                    ex_top0 = top1_reg;
                    ex_top1 = top0_reg;
                end
            end
            tos_pkg::ACT_ROT:
            begin
                if (count_reg < CW'(3))
                begin
                    ex_status = tos_pkg::ST_UNDER;
                end
                else
                begin
                    ex_top0 = top2_reg;
                    ex_top1 = top0_reg;
                    ex_top2 = top1_reg;
                end
            end
            tos_pkg::ACT_PICK:
            begin
                if (count_reg < CW'(2))
                begin
                    ex_status = tos_pkg::ST_UNDER;
                end
                else if (pick_bad)
                begin
                    ex_status = tos_pkg::ST_PICK;
                end
                else
                begin
                    ex_top0 = pick_entry;
                end
            end
            tos_pkg::ACT_TO_CHAR:
            begin
                if (count_reg == CW'(0))
                begin
                    ex_status = tos_pkg::ST_UNDER;
                end
                else
                begin
                    ex_top0.value = {{56{top0_reg.value[7]}}, top0_reg.value[7:0]};
                    ex_top0.tag   = tos_pkg::TAG_CHAR;
                end
            end
            default:
            begin
                ex_status = tos_pkg::ST_OK;
            end
        endcase
        if (ex_push)
        begin
            ex_count = count_reg + CW'(1);
            ex_top0  = ex_push_entry;
            ex_top1  = top0_reg;
            ex_top2  = top1_reg;
        end
    end

    // Result word: the popped entry for pop, else the new top or zero.
    always_comb
    begin
        if (ex_popped)
        begin
            ex_result_value = top0_reg.value;
            ex_result_type  = top0_reg.tag;
        end
        else if (ex_count != CW'(0))
        begin
            ex_result_value = ex_top0.value;
            ex_result_type  = ex_top0.tag;
        end
        else
        begin
            ex_result_value = '0;
            ex_result_type  = tos_pkg::TAG_INT;
        end
    end

    // Next state holds when no command fires, so the memory reads stay aimed.
    assign count_next = exec_fire ? ex_count : count_reg;
    assign top0_next  = exec_fire ? ex_top0 : top0_reg;
    assign top1_next  = exec_fire ? ex_top1 : top1_reg;
    assign top2_next  = exec_fire ? ex_top2 : top2_reg;

    // A push spills the third entry into memory; reads track the next state.
    assign mem_we      = exec_fire && ex_push && (count_reg >= CW'(3));
    assign mem_waddr   = AW'(count_reg - CW'(3));
    assign mem_raddr_a = AW'(count_next - CW'(4));
    assign mem_raddr_b = AW'(count_next) - AW'(2) - top0_next.value[AW-1:0];

    tos_entry_mem #(
        .AW (AW)
    ) u_entry_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (top2_reg),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (fourth_entry),
        .rdata_b (pick_fetch)
    );

    // Stack state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top0_reg <= top0_next;
        top1_reg <= top1_next;
        top2_reg <= top2_next;
    end

    // Result register with its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            res_value_reg  <= ex_result_value;
            res_type_reg   <= ex_result_type;
            res_depth_reg  <= 7'(ex_count);
            res_status_reg <= ex_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_value_reg;
    assign result_type  = res_type_reg;
    assign stack_depth  = res_depth_reg;
    assign status       = res_status_reg;

    // Checks on the stack bookkeeping.
    `TOS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(STACK_DEPTH), "stack count beyond depth")
    `TOS_ASSERT_NOW(a_spill_range, mem_we,
        count_reg >= CW'(3) && count_reg < CW'(STACK_DEPTH), "spill with bad count")
    `TOS_ASSERT_NEXT(a_error_holds, exec_fire && ex_status != tos_pkg::ST_OK,
        $stable(count_reg), "failed command changed count")
    `TOS_ASSERT_NEXT(a_push_grows,
        exec_fire && ex_status == tos_pkg::ST_OK
            && (act_reg == tos_pkg::ACT_PUSH || act_reg == tos_pkg::ACT_DUP),
        count_reg == $past(count_reg) + CW'(1), "push did not grow stack")

endmodule

@@ hdl/tos_entry_mem.sv @@
module tos_entry_mem #(
    parameter int AW = 6
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  tos_pkg::entry_t wdata,
    input  logic [AW-1:0]  raddr_a,
    input  logic [AW-1:0]  raddr_b,
    output tos_pkg::entry_t rdata_a,
    output tos_pkg::entry_t rdata_b
);

    localparam int WORDS = 1 << AW;

    tos_pkg::entry_t store_reg [WORDS];
    tos_pkg::entry_t rd_a_reg;
    tos_pkg::entry_t rd_b_reg;

    // One write port and two registered read ports. A read of the address
    // being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr_a))
        begin
            rd_a_reg <= wdata;
        end
        else
        begin
            rd_a_reg <= store_reg[raddr_a];
        end
        if (we && (waddr == raddr_b))
        begin
            rd_b_reg <= wdata;
        end
        else
        begin
            rd_b_reg <= store_reg[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS = 64;

    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_PICK} mix_t;

    // One expected output word.
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  tag;
        logic [6:0]  depth;
        logic [1:0]  st;
    } stack_result_t;

    // Mirrors the operand stack and holds the output words still to come.
    class operand_stack_tracker;
        logic [63:0]   slot_value [SLOTS];
        logic [1:0]    slot_tag [SLOTS];
        int unsigned   count;
        stack_result_t pending_results [$];
        int            mismatches;

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Applies one accepted command to the mirror and queues its result.
        function void note_command(logic [2:0] act, logic [63:0] pv, logic [1:0] pt);
            stack_result_t r;
            int unsigned   n;
            int unsigned   src;
            logic [1:0]    st;
            logic [63:0]   rv;
            logic [1:0]    rt;
            logic [63:0]   idx;
            bit            popped;
            n = count;
            st = tos_pkg::ST_OK;
            rv = '0;
            rt = tos_pkg::TAG_INT;
            popped = 1'b0;
            if (pt == tos_pkg::TAG_UNUSED)
                pt = tos_pkg::TAG_INT;
            case (act)
                tos_pkg::ACT_PUSH:
                    if (n >= SLOTS)
                        st = tos_pkg::ST_OVER;
                    else
                    begin
                        slot_value[n] = pv;
                        slot_tag[n] = pt;
                        n++;
                    end
                tos_pkg::ACT_POP:
                    if (n < 1)
                        st = tos_pkg::ST_UNDER;
                    else
                    begin
                        rv = slot_value[n-1];
                        rt = slot_tag[n-1];
                        popped = 1'b1;
                        n--;
                    end
                tos_pkg::ACT_DUP:
                    if (n < 1)
                        st = tos_pkg::ST_UNDER;
                    else if (n >= SLOTS)
                        st = tos_pkg::ST_OVER;
                    else
                    begin
                        slot_value[n] = slot_value[n-1];
                        slot_tag[n] = slot_tag[n-1];
                        n++;
                    end
                tos_pkg::ACT_SWAP:
                    if (n < 2)
                        st = tos_pkg::ST_UNDER;
                    else
                    begin
                        {slot_value[n-1], slot_value[n-2]} = {slot_value[n-2], slot_value[n-1]};
                        {slot_tag[n-1], slot_tag[n-2]} = {slot_tag[n-2], slot_tag[n-1]};
                    end
                tos_pkg::ACT_ROT:
                    if (n < 3)
                        st = tos_pkg::ST_UNDER;
                    else
                    begin
                        // The third entry comes up; the top two move down by one.
                        {slot_value[n-1], slot_value[n-2], slot_value[n-3]} =
                            {slot_value[n-3], slot_value[n-1], slot_value[n-2]};
                        {slot_tag[n-1], slot_tag[n-2], slot_tag[n-3]} =
                            {slot_tag[n-3], slot_tag[n-1], slot_tag[n-2]};
                    end
                tos_pkg::ACT_PICK:
                    if (n < 2)
                        st = tos_pkg::ST_UNDER;
                    else
                    begin
                        // The top is a signed index into what lies below it.
                        idx = slot_value[n-1];
                        if (idx[63] || idx >= 64'(n - 1))
                            st = tos_pkg::ST_PICK;
                        else
                        begin
                            src = n - 2 - int'(idx);
                            slot_value[n-1] = slot_value[src];
                            slot_tag[n-1] = slot_tag[src];
                        end
                    end
                tos_pkg::ACT_TO_CHAR:
                    if (n < 1)
                        st = tos_pkg::ST_UNDER;
                    else
                    begin
                        slot_value[n-1] = {{56{slot_value[n-1][7]}}, slot_value[n-1][7:0]};
                        slot_tag[n-1] = tos_pkg::TAG_CHAR;
                    end
                default:
                    ;
            endcase
            count = n;
            if (!popped && n > 0)
            begin
                rv = slot_value[n-1];
                rt = slot_tag[n-1];
            end
            r.value = rv;
            r.tag = rt;
            r.depth = n[6:0];
            r.st = st;
            pending_results.push_back(r);
        endfunction

        // Compares one accepted output word with the oldest expectation.
        task check_result(logic [63:0] value, logic [1:0] tag, logic [6:0] depth,
                          logic [1:0] st);
            stack_result_t e;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word value %h", value));
                return;
            end
            e = pending_results.pop_front();
            if (value !== e.value)
                report_mismatch($sformatf("value %h, expected %h", value, e.value));
            if (tag !== e.tag)
                report_mismatch($sformatf("tag %0d, expected %0d", tag, e.tag));
            if (depth !== e.depth)
                report_mismatch($sformatf("depth %0d, expected %0d", depth, e.depth));
            if (st !== e.st)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.st));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         action = tos_pkg::ACT_NOP;
    logic signed [63:0] push_value = '0;
    logic [1:0]         push_type = tos_pkg::TAG_INT;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] result_value;
    logic [1:0]         result_type;
    logic [6:0]         stack_depth;
    logic [1:0]         status;

    // When set, neither side idles.
    bit quiet = 1'b0;

    operand_stack_tracker tracker = new();

    typed_operand_stack_core #(
        .STACK_DEPTH(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .push_value(push_value),
        .push_type(push_type),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_value(result_value),
        .result_type(result_type),
        .stack_depth(stack_depth),
        .status(status)
    );

    always #5 clk = ~clk;

    // Idle cycles before the next word on either side.
    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Mixes full-width values, small indexes and the extremes.
    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 70));
            1: return -64'($urandom_range(1, 70));
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] choose_action(mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                if (r < 60)
                    return tos_pkg::ACT_PUSH;
                else if (r < 70)
                    return tos_pkg::ACT_DUP;
            MIX_DRAIN:
                if (r < 55)
                    return tos_pkg::ACT_POP;
            default:
                if (r < 25)
                    return tos_pkg::ACT_PUSH;
        endcase
        return 3'($urandom_range(0, 7));
    endfunction

    // Offers one word and returns at the edge that accepts it.
    task automatic send_word(logic [2:0] act, logic [63:0] val, logic [1:0] typ);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= act;
        push_value <= val;
        push_type <= typ;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.note_command(act, val, typ);
    endtask

    // Stops sending until every expected word has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic directed_checks();
        // Pop, dup, to_char, swap and nop on an empty stack, then the shallow underflows.
        send_word(tos_pkg::ACT_POP, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_DUP, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_TO_CHAR, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_SWAP, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_NOP, '1, tos_pkg::TAG_UNUSED);
        send_word(tos_pkg::ACT_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_SWAP, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PICK, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PUSH, 64'h8000_0000_0000_0000, tos_pkg::TAG_UNUSED);
        send_word(tos_pkg::ACT_ROT, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PUSH, 64'h1234_5678_9ABC_DEF0, tos_pkg::TAG_DOUBLE);
        send_word(tos_pkg::ACT_ROT, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_SWAP, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_DUP, '0, tos_pkg::TAG_INT);
        // Character conversion with the sign bit of the low byte set and clear.
        send_word(tos_pkg::ACT_TO_CHAR, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PUSH, 64'hFFFF_0000_0000_007F, tos_pkg::TAG_DOUBLE);
        send_word(tos_pkg::ACT_TO_CHAR, '0, tos_pkg::TAG_INT);
        // Pick with index zero, a deeper index, a negative one and one too large.
        send_word(tos_pkg::ACT_PUSH, 64'd0, tos_pkg::TAG_CHAR);
        send_word(tos_pkg::ACT_PICK, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PUSH, 64'd2, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PICK, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PICK, '0, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PUSH, 64'd100, tos_pkg::TAG_INT);
        send_word(tos_pkg::ACT_PICK, '0, tos_pkg::TAG_INT);
    endtask

    // Random commands; pick is mostly fed a freshly pushed index from zero to the depth, or a small negative one.
    task automatic run_phase(mix_t mix, int items);
        int          sent;
        int unsigned c;
        logic [63:0] idx;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 99) < ((mix == MIX_PICK) ? 40 : 10))
            begin
                c = tracker.count;
                if ($urandom_range(0, 7) == 0)
                    idx = -64'($urandom_range(1, 5));
                else
                    idx = 64'($urandom_range(0, c));
                send_word(tos_pkg::ACT_PUSH, idx, 2'($urandom_range(0, 3)));
                send_word(tos_pkg::ACT_PICK, rand_value(), 2'($urandom_range(0, 3)));
                sent += 2;
            end
            else
            begin
                send_word(choose_action(mix), rand_value(), 2'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    // Receiver: stalls a random number of cycles before taking each word.
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            k = draw_wait();
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.check_result(result_value, result_type, stack_depth, status);
    end

    // Main sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        hold_until_drained();
        run_phase(MIX_BALANCED, 170);
        hold_until_drained();
        run_phase(MIX_FILL, 170);
        hold_until_drained();
        run_phase(MIX_DRAIN, 170);
        hold_until_drained();
        quiet = 1'b1;
        run_phase(MIX_PICK, 170);
        hold_until_drained();
        quiet = 1'b0;
        run_phase(MIX_FILL, 100);
        run_phase(MIX_PICK, 70);
        hold_until_drained();
        // Let any stray word show up before the verdict.
        repeat (12) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #3_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
